>>> rtl/core/ssaa_pkg.sv
package ssaa_pkg;

  localparam int unsigned PIX_W     = 32;
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned ROW_W     = 9;
  localparam int unsigned PROD_W    = 16;
  localparam int unsigned WEIGHT_W  = 10;
  localparam int unsigned ACC_W     = 18;
  localparam int unsigned QUOT_W    = 16;
  localparam int unsigned NUM_SUB   = 4;
  localparam int unsigned NUM_CHAN  = 3;

  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_BEHIND_MODE   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLAYFIELD_TOP = 8'd1;

  localparam logic [ROW_W-1:0]    PLAYFIELD_TOP_RESET = 9'd32;
  localparam logic [WEIGHT_W-1:0] FULL_WEIGHT         = 10'd1020;
  localparam logic [ACC_W-1:0]    HALF_WEIGHT         = 18'd510;
  localparam logic [CHAN_W-1:0]   OPAQUE_ALPHA        = 8'hFF;

  // floor(y / 255) = (y * RECIP_255) >> RECIP_SHIFT, exact for 16-bit y
  localparam logic [QUOT_W-1:0]   RECIP_255   = 16'h8081;
  localparam int unsigned         RECIP_SHIFT = 23;

  typedef struct packed {
    logic             valid;
    logic             wr;
    logic [PIX_W-1:0] dest;
  } ctl_t;

  typedef logic [NUM_CHAN-1:0][NUM_SUB-1:0][PROD_W-1:0] prod_arr_t;
  typedef logic [NUM_CHAN-1:0][ACC_W-1:0]               acc_arr_t;

endpackage

>>> rtl/core/ssaa_2x2_resolve_alpha_composite.sv
// 2x2 supersample resolve with alpha "over" composite onto the frame.
//
// Input: one pixel beat is taken at each rising edge with start high and
// busy low. busy stays low, so a new pixel may enter every cycle; the rate
// is one pixel per clock, set by the three-stage pipeline (multiply,
// accumulate, reciprocal divide) that takes a new beat each cycle.
// Output: done pulses for one cycle with out_pixel and write_enable; the
// result is registered in the multiply, accumulate and divide stages in turn,
// and no stall comes between them. Results leave in input order. The
// receiver cannot hold results off, and none is needed: nothing stalls.
// Config: a write beat on cfg_valid/cfg_ready (ready always high) sets
// register cfg_index from cfg_data: index 0 behind_mode, index 1
// playfield_top; other indexes are ignored. Write only while idle.
// Reset: rst (synchronous) clears the pipeline valid bits, sets
// behind_mode to 0 and playfield_top to 32.
module ssaa_2x2_resolve_alpha_composite
  import ssaa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [PIX_W-1:0]     sub_top_left,
  input  logic [PIX_W-1:0]     sub_top_right,
  input  logic [PIX_W-1:0]     sub_bottom_left,
  input  logic [PIX_W-1:0]     sub_bottom_right,
  input  logic [PIX_W-1:0]     dest_pixel,
  input  logic [ROW_W-1:0]     row,
  input  logic                 bg_opaque,
  output logic                 done,
  output logic [PIX_W-1:0]     out_pixel,
  output logic                 write_enable,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  logic                behind_mode;
  logic [ROW_W-1:0]    playfield_top;
  logic                accept;
  ctl_t                ctl_s1;
  ctl_t                ctl_s2;
  prod_arr_t           prod;
  logic [WEIGHT_W-1:0] weight;
  acc_arr_t            acc;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      behind_mode   <= 1'b0;
      playfield_top <= PLAYFIELD_TOP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BEHIND_MODE:   behind_mode   <= cfg_data[0];
        REG_PLAYFIELD_TOP: playfield_top <= cfg_data[ROW_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ssaa_mul u_mul (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .sub_top_left     (sub_top_left),
    .sub_top_right    (sub_top_right),
    .sub_bottom_left  (sub_bottom_left),
    .sub_bottom_right (sub_bottom_right),
    .dest_pixel       (dest_pixel),
    .row              (row),
    .bg_opaque        (bg_opaque),
    .behind_mode      (behind_mode),
    .playfield_top    (playfield_top),
    .ctl              (ctl_s1),
    .prod             (prod),
    .weight           (weight)
  );

  ssaa_acc u_acc (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (ctl_s1),
    .prod    (prod),
    .weight  (weight),
    .ctl_out (ctl_s2),
    .acc     (acc)
  );

  ssaa_div u_div (
    .clk          (clk),
    .rst          (rst),
    .ctl_in       (ctl_s2),
    .acc          (acc),
    .done         (done),
    .out_pixel    (out_pixel),
    .write_enable (write_enable)
  );

  a_done_from_beat: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 3))
    else $error("result without an accepted beat");

  a_beat_gives_done: assert property (@(posedge clk) disable iff (rst)
    ctl_s2.valid |=> done)
    else $error("accumulated beat lost before output");

  a_we_needs_done: assert property (@(posedge clk)
    !done |-> !write_enable)
    else $error("write_enable outside a result");

  a_written_opaque: assert property (@(posedge clk) disable iff (rst)
    (done && write_enable) |-> (out_pixel[PIX_W-1 -: CHAN_W] == OPAQUE_ALPHA))
    else $error("written pixel not opaque");

endmodule

>>> rtl/core/ssaa_mul.sv
module ssaa_mul
  import ssaa_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [PIX_W-1:0] sub_top_left,
  input  logic [PIX_W-1:0] sub_top_right,
  input  logic [PIX_W-1:0] sub_bottom_left,
  input  logic [PIX_W-1:0] sub_bottom_right,
  input  logic [PIX_W-1:0] dest_pixel,
  input  logic [ROW_W-1:0] row,
  input  logic             bg_opaque,
  input  logic             behind_mode,
  input  logic [ROW_W-1:0] playfield_top,
  output ctl_t             ctl,
  output prod_arr_t        prod,
  output logic [WEIGHT_W-1:0] weight
);

  logic [NUM_SUB-1:0][PIX_W-1:0] sub;
  prod_arr_t                     prod_next;
  logic [WEIGHT_W-1:0]           asum;
  logic                          wr_next;

  assign sub = {sub_bottom_right, sub_bottom_left, sub_top_right, sub_top_left};

  always_comb begin
    asum = '0;
    for (int i = 0; i < NUM_SUB; i++) begin
      asum = asum + WEIGHT_W'(sub[i][PIX_W-1 -: CHAN_W]);
    end
    for (int c = 0; c < NUM_CHAN; c++) begin
      for (int i = 0; i < NUM_SUB; i++) begin
        prod_next[c][i] = PROD_W'(sub[i][c*CHAN_W +: CHAN_W]) *
                          PROD_W'(sub[i][PIX_W-1 -: CHAN_W]);
      end
    end
    wr_next = (row >= playfield_top) && !(behind_mode && bg_opaque) && (asum != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else begin
      ctl.valid <= accept;
    end
    ctl.wr   <= wr_next;
    ctl.dest <= dest_pixel;
    prod     <= prod_next;
    weight   <= FULL_WEIGHT - asum;
  end

endmodule

>>> rtl/core/ssaa_acc.sv
module ssaa_acc
  import ssaa_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  ctl_t                ctl_in,
  input  prod_arr_t           prod,
  input  logic [WEIGHT_W-1:0] weight,
  output ctl_t                ctl_out,
  output acc_arr_t            acc
);

  acc_arr_t acc_next;

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      acc_next[c] = HALF_WEIGHT + ACC_W'(ctl_in.dest[c*CHAN_W +: CHAN_W]) * ACC_W'(weight);
      for (int i = 0; i < NUM_SUB; i++) begin
        acc_next[c] = acc_next[c] + ACC_W'(prod[c][i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_out.valid <= ctl_in.valid;
    end
    ctl_out.wr   <= ctl_in.wr;
    ctl_out.dest <= ctl_in.dest;
    acc          <= acc_next;
  end

endmodule

>>> rtl/core/ssaa_div.sv
module ssaa_div
  import ssaa_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  ctl_t             ctl_in,
  input  acc_arr_t         acc,
  output logic             done,
  output logic [PIX_W-1:0] out_pixel,
  output logic             write_enable
);

  logic [NUM_CHAN-1:0][CHAN_W-1:0] quot;
  logic [2*QUOT_W-1:0]             scaled [NUM_CHAN];
  logic [PIX_W-1:0]                pixel_next;

  // divide by 1020: drop the factor of four, then multiply by the reciprocal of 255
  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      scaled[c] = (2*QUOT_W)'(acc[c][ACC_W-1:2]) * (2*QUOT_W)'(RECIP_255);
      quot[c]   = scaled[c][RECIP_SHIFT +: CHAN_W];
    end
    pixel_next = ctl_in.wr ? {OPAQUE_ALPHA, quot[2], quot[1], quot[0]} : ctl_in.dest;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done         <= 1'b0;
      write_enable <= 1'b0;
    end else begin
      done         <= ctl_in.valid;
      write_enable <= ctl_in.valid && ctl_in.wr;
    end
    out_pixel <= pixel_next;
  end

endmodule

>>> tb/ssaa_resolve_checker.sv
`timescale 1ns / 100ps
module ssaa_resolve_checker
  import ssaa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  logic [PIX_W-1:0]     sub_top_left,
  input  logic [PIX_W-1:0]     sub_top_right,
  input  logic [PIX_W-1:0]     sub_bottom_left,
  input  logic [PIX_W-1:0]     sub_bottom_right,
  input  logic [PIX_W-1:0]     dest_pixel,
  input  logic [ROW_W-1:0]     row,
  input  logic                 bg_opaque,
  input  logic                 done,
  input  logic [PIX_W-1:0]     out_pixel,
  input  logic                 write_enable,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  output int unsigned          fail_count,
  output int unsigned          pending
);

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             wr_en;
  } frame_write_t;

  frame_write_t     pending_writes [$];
  logic             hide_behind_bg;
  logic [ROW_W-1:0] first_open_row;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report_mismatch(input string what, input logic [PIX_W-1:0] got,
                                 input logic [PIX_W-1:0] want);
    $display("mismatch on %s at %0t: got %h, want %h", what, $time, got, want);
    fail_count++;
  endtask

  function automatic frame_write_t resolve_pixel(
    input logic [NUM_SUB-1:0][PIX_W-1:0] subs,
    input logic [PIX_W-1:0]              dest,
    input logic [ROW_W-1:0]              pix_row,
    input logic                          bgop
  );
    frame_write_t res;
    int unsigned  coverage;
    int unsigned  acc;
    res.pixel = dest;
    res.wr_en = 1'b0;
    coverage = 0;
    for (int i = 0; i < NUM_SUB; i++) begin
      coverage += subs[i][PIX_W-1 -: CHAN_W];
    end
    if (pix_row < first_open_row || (hide_behind_bg && bgop) || coverage == 0) begin
      return res;
    end
    res.pixel[PIX_W-1 -: CHAN_W] = OPAQUE_ALPHA;
    for (int c = 0; c < NUM_CHAN; c++) begin
      acc = dest[c*CHAN_W +: CHAN_W] * (FULL_WEIGHT - coverage);
      for (int i = 0; i < NUM_SUB; i++) begin
        acc += subs[i][c*CHAN_W +: CHAN_W] * subs[i][PIX_W-1 -: CHAN_W];
      end
      acc = (acc + HALF_WEIGHT) / FULL_WEIGHT;
      res.pixel[c*CHAN_W +: CHAN_W] = acc[CHAN_W-1:0];
    end
    res.wr_en = 1'b1;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    frame_write_t want;
    if (rst) begin
      hide_behind_bg = 1'b0;
      first_open_row = PLAYFIELD_TOP_RESET;
      pending_writes.delete();
    end else begin
      if (done !== 1'b0) begin
        if (pending_writes.size() == 0) begin
          report_mismatch("result with no pixel pending", out_pixel, '0);
        end else begin
          want = pending_writes.pop_front();
          if (out_pixel !== want.pixel) begin
            report_mismatch("out_pixel", out_pixel, want.pixel);
          end
          if (write_enable !== want.wr_en) begin
            report_mismatch("write_enable", PIX_W'(write_enable), PIX_W'(want.wr_en));
          end
        end
      end
      if (start && !busy) begin
        pending_writes.push_back(resolve_pixel(
          {sub_bottom_right, sub_bottom_left, sub_top_right, sub_top_left},
          dest_pixel, row, bg_opaque));
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BEHIND_MODE:   hide_behind_bg = cfg_data[0];
          REG_PLAYFIELD_TOP: first_open_row = cfg_data[ROW_W-1:0];
          default: ;
        endcase
      end
    end
    pending = pending_writes.size();
  end

endmodule

>>> tb/tb_ssaa_2x2_resolve_alpha_composite.sv
`timescale 1ns / 100ps
module tb_ssaa_2x2_resolve_alpha_composite;
  import ssaa_pkg::*;

  localparam int unsigned          CYCLE_LIMIT      = 200000;
  localparam int unsigned          RANDOM_PIXELS    = 600;
  localparam int unsigned          RANDOM_PHASES    = 6;
  localparam int unsigned          SETTLE_CYCLES    = 8;
  localparam int unsigned          ROW_MAX          = (1 << ROW_W) - 1;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_UNUSED  = 8'hFF;

  typedef enum int unsigned {ALPHA_CLEAR, ALPHA_SOLID, ALPHA_MIXED, ALPHA_SPARSE} alpha_mix_t;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [PIX_W-1:0]     sub_top_left;
  logic [PIX_W-1:0]     sub_top_right;
  logic [PIX_W-1:0]     sub_bottom_left;
  logic [PIX_W-1:0]     sub_bottom_right;
  logic [PIX_W-1:0]     dest_pixel;
  logic [ROW_W-1:0]     row;
  logic                 bg_opaque;
  logic                 done;
  logic [PIX_W-1:0]     out_pixel;
  logic                 write_enable;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;
  int unsigned          fail_count;
  int unsigned          pending;
  int unsigned          cycles;
  int unsigned          idle_pct;
  logic [ROW_W-1:0]     cur_top;

  ssaa_2x2_resolve_alpha_composite uut (.*);

  ssaa_resolve_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial cycles = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_pixel(input logic [NUM_SUB-1:0][PIX_W-1:0] subs,
                            input logic [PIX_W-1:0] dest,
                            input logic [ROW_W-1:0] pix_row, input logic bgop);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start            <= 1'b1;
    sub_top_left     <= subs[0];
    sub_top_right    <= subs[1];
    sub_bottom_left  <= subs[2];
    sub_bottom_right <= subs[3];
    dest_pixel       <= dest;
    row              <= pix_row;
    bg_opaque        <= bgop;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // hold start low until every pending pixel has come back
  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // upper data bits are random: the block must drop them
  task automatic configure(input logic behind, input logic [ROW_W-1:0] first_row);
    wait_idle();
    write_reg(REG_BEHIND_MODE, ($urandom & 32'hFFFF_FFFE) | CFG_DAT_W'(behind));
    write_reg(REG_PLAYFIELD_TOP, ($urandom & ~CFG_DAT_W'(ROW_MAX)) | CFG_DAT_W'(first_row));
    write_reg(CFG_IDX_W'($urandom_range(REG_LAST_UNUSED, REG_FIRST_UNUSED)), $urandom);
    cur_top = first_row;
  endtask

  function automatic logic [NUM_SUB-1:0][PIX_W-1:0] random_subs(input alpha_mix_t mix);
    logic [NUM_SUB-1:0][PIX_W-1:0] s;
    for (int i = 0; i < NUM_SUB; i++) begin
      s[i] = $urandom;
      case (mix)
        ALPHA_CLEAR:  s[i][PIX_W-1 -: CHAN_W] = '0;
        ALPHA_SOLID:  s[i][PIX_W-1 -: CHAN_W] = OPAQUE_ALPHA;
        ALPHA_SPARSE: if ($urandom_range(1)) s[i][PIX_W-1 -: CHAN_W] = '0;
        default: ;
      endcase
    end
    return s;
  endfunction

  task automatic send_random_pixel();
    alpha_mix_t       mix;
    logic [ROW_W-1:0] pix_row;
    int unsigned      pick;
    pick = $urandom_range(9);
    if (pick == 0) mix = ALPHA_CLEAR;
    else if (pick < 3) mix = ALPHA_SOLID;
    else if (pick < 5) mix = ALPHA_SPARSE;
    else mix = ALPHA_MIXED;
    if ($urandom_range(9) < 7) pix_row = ROW_W'($urandom_range(ROW_MAX, cur_top));
    else pix_row = ROW_W'($urandom);
    send_pixel(random_subs(mix), $urandom, pix_row, 1'($urandom));
  endtask

  initial begin
    rst              = 1'b1;
    start            = 1'b0;
    sub_top_left     = '0;
    sub_top_right    = '0;
    sub_bottom_left  = '0;
    sub_bottom_right = '0;
    dest_pixel       = '0;
    row              = '0;
    bg_opaque        = 1'b0;
    cfg_valid        = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    idle_pct         = 15;
    cur_top          = PLAYFIELD_TOP_RESET;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // registers at their reset values
    send_pixel({4{32'hFFFF_FFFF}}, 32'h0000_0000, 9'd0, 1'b0);
    send_pixel({4{32'hFFFF_FFFF}}, 32'h0000_0000, 9'd31, 1'b0);
    send_pixel({4{32'hFFFF_FFFF}}, 32'h0000_0000, 9'd32, 1'b0);
    send_pixel({4{32'hFF00_0000}}, 32'hFFFF_FFFF, 9'd511, 1'b1);
    send_pixel({4{32'h00FF_FFFF}}, 32'hA512_3456, 9'd100, 1'b0);
    send_pixel({32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h01FF_FFFF},
               32'h0000_0000, 9'd40, 1'b0);
    send_pixel({32'h00FF_FFFF, 32'h4000_FF00, 32'h80FF_0000, 32'hFF00_00FF},
               32'h7F80_8080, 9'd200, 1'b1);
    send_pixel({32'h7F80_8080, 32'h0101_0101, 32'hFE7F_7F7F, 32'h0380_0180},
               32'hFF01_FE80, 9'd300, 1'b0);
    send_pixel({4{32'h3F12_3456}}, 32'h5AAB_CDEF, 9'd33, 1'b0);

    // overlay behind opaque background, every row open
    configure(1'b1, 9'd0);
    send_pixel({4{32'hFFFF_FFFF}}, 32'h1234_5678, 9'd0, 1'b1);
    send_pixel({4{32'hFFFF_FFFF}}, 32'h1234_5678, 9'd0, 1'b0);
    send_pixel({4{32'h00FF_FFFF}}, 32'h1234_5678, 9'd5, 1'b0);
    send_pixel({4{32'h80C0_4020}}, 32'hFF00_FF00, 9'd511, 1'b0);

    // only the last row open
    configure(1'b0, 9'd511);
    send_pixel({4{32'hFFAB_CDEF}}, 32'h0000_0000, 9'd510, 1'b0);
    send_pixel({4{32'hFFAB_CDEF}}, 32'h0000_0000, 9'd511, 1'b1);
    send_pixel({4{32'h0000_0000}}, 32'hFFFF_FFFF, 9'd511, 1'b0);

    configure(1'b0, 9'd0);
    send_pixel({32'hFF00_0000, 32'h00FF_FFFF, 32'hFF00_0000, 32'h00FF_FFFF},
               32'h00FF_FFFF, 9'd0, 1'b1);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: configure(1'b0, 9'd32);
        1: configure(1'b1, 9'd0);
        2: configure(1'b0, 9'd0);
        3: configure(1'b1, 9'd511);
        4: configure(1'b0, ROW_W'($urandom));
        default: configure(1'b1, ROW_W'($urandom_range(64)));
      endcase
      idle_pct = (phase == 2) ? 0 : 15;
      for (int n = 0; n < RANDOM_PIXELS / RANDOM_PHASES; n++) begin
        if (phase == 0 && n == 50) wait_idle();
        send_random_pixel();
      end
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
